### design/bsb_pkg.sv
package bsb_pkg;

   // One element of a batch, two's complement.
   typedef logic signed [31:0] value_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;   // place the incoming value in sorted position
      logic shift;    // move every held value one cell toward the head
   } cell_ctrl_type;

endpackage

### design/bubble_sort_block.sv
// Stable ascending sorter for batches of signed 32-bit values. Send the
// values of a batch one beat each on req_, marking the final one with
// req_last; the block takes one beat per cycle while loading, each beat
// dropped into its sorted place in a chain of MAX_ITEMS compare cells.
// After the last beat the chain drains from its head on rsp_, one result
// beat per cycle when rsp_stall is low, smallest first, equal values in
// arrival order, the final one flagged by rsp_last_out. While the batch
// drains, req_stall is high, so no new batch is taken until every held
// value (at most MAX_ITEMS) has left the chain. Beats past MAX_ITEMS in
// a batch are dropped and rsp_overflow is set on every result of that
// batch.
module bubble_sort_block
   import bsb_pkg::*;
#(
   parameter int MAX_ITEMS = 64
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  value_type req_value,
   input  logic      req_last,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output value_type rsp_sorted_value,
   output logic      rsp_last_out,
   output logic      rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;

   logic          req_beat, rsp_beat, has_room;
   cell_ctrl_type ctrl;

   value_type cell_value [MAX_ITEMS];
   logic      cell_occ   [MAX_ITEMS];
   logic      cell_gt    [MAX_ITEMS];

   assign req_stall = (state_ff == ST_DRAIN);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign has_room  = (count_ff < CNT_W'(MAX_ITEMS));

   // Insert only when there is room; the tail cell is then always empty.
   assign ctrl.insert = req_beat && has_room;
   assign ctrl.shift  = rsp_beat;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic      prev_gt, prev_occ, next_occ;
      value_type prev_value, next_value;

      if (i == 0) begin : g_head
         assign prev_gt    = 1'b0;
         assign prev_value = '0;
         assign prev_occ   = 1'b0;
      end else begin : g_body
         assign prev_gt    = cell_gt[i-1];
         assign prev_value = cell_value[i-1];
         assign prev_occ   = cell_occ[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign next_value = '0;
         assign next_occ   = 1'b0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_occ   = cell_occ[i+1];
      end

      bsb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (req_value),
         .prev_gt    (prev_gt),
         .prev_value (prev_value),
         .prev_occ   (prev_occ),
         .next_value (next_value),
         .next_occ   (next_occ),
         .gt         (cell_gt[i]),
         .held_value (cell_value[i]),
         .occ        (cell_occ[i])
      );
   end

   // Sequence load and drain; count tracks values held in the chain.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               // a batch always holds at least one value when it ends
               if (req_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_beat) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // Head of the chain is the next result.
   assign rsp_sorted_value = cell_value[0];
   assign rsp_last_out     = (count_ff == CNT_W'(1));
   assign rsp_overflow     = dropped_ff;

endmodule

### design/bsb_cell.sv
module bsb_cell
   import bsb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  value_type     new_value,
   input  logic          prev_gt,
   input  value_type     prev_value,
   input  logic          prev_occ,
   input  value_type     next_value,
   input  logic          next_occ,
   output logic          gt,
   output value_type     held_value,
   output logic          occ
);

   value_type value_ff, value_in;
   logic      occ_ff, occ_in;

   // An empty cell acts as plus infinity; equal values stay put so that
   // later arrivals land behind them.
   assign gt = !occ_ff || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (ctrl.shift) begin
         value_in = next_value;
         occ_in   = next_occ;
      end else if (ctrl.insert && gt) begin
         if (prev_gt) begin
            value_in = prev_value;
            occ_in   = prev_occ;
         end else begin
            value_in = new_value;
            occ_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign held_value = value_ff;
   assign occ        = occ_ff;

endmodule

### design/bsb_checker.sv
module bsb_checker
   import bsb_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_stall,
   input logic      rsp_valid,
   input logic      rsp_stall,
   input value_type rsp_sorted_value,
   input logic      rsp_last_out,
   input logic      rsp_overflow
);

   logic      rsp_beat;
   logic      mid_ff, mid_in;
   value_type prev_ff;
   logic      prev_ovf_ff;

   assign rsp_beat = rsp_valid && !rsp_stall;

   always_comb begin
      mid_in = mid_ff;
      if (rsp_beat) begin
         mid_in = !rsp_last_out;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_beat) begin
         prev_ff     <= rsp_sorted_value;
         prev_ovf_ff <= rsp_overflow;
      end
      if (reset) begin
         mid_ff <= 1'b0;
      end else begin
         mid_ff <= mid_in;
      end
   end

   // No new batch enters while results are pending.
   a_no_load_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while results pending");

   // Results of one batch ascend.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && mid_ff) |-> (rsp_sorted_value >= prev_ff))
      else $error("results out of order");

   // Overflow flag is the same on every result of a batch.
   a_overflow_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && mid_ff) |-> (rsp_overflow == prev_ovf_ff))
      else $error("overflow changed within a batch");

   // Stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sorted_value)))
      else $error("stalled result changed");

endmodule

bind bubble_sort_block bsb_checker u_bsb_checker (.*);
